// ===== hw/rtl/heightmap_triangle_interpolator_macros.svh =====
// assertion macros shared by the heightmap interpolator rtl
`ifndef HEIGHTMAP_TRIANGLE_INTERPOLATOR_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_INTERPOLATOR_MACROS_SVH

// property must hold at every clock edge out of reset
`define HTRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define HTRI_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/htri_pkg.sv =====
// shared types, constants and field layout of the heightmap interpolator
package htri_pkg;

  localparam int unsigned DEF_MAX_COLUMNS = 256;
  localparam int unsigned DEF_MAX_ROWS    = 256;
  localparam int unsigned DEF_FRAC_BITS   = 16;

  localparam int unsigned POS_W  = 32;
  localparam int unsigned HGT_W  = 32;
  localparam int unsigned HALF_W = 31;
  localparam int unsigned INV_W  = 32;
  localparam int unsigned CNT_W  = 9;
  localparam int unsigned CELL_W = 8;
  localparam int unsigned IDX_W  = 9;
  localparam int unsigned SUM_W  = POS_W + 1;

  // input tdata layout, lowest bit first
  localparam int unsigned POSX_LSB  = 0;
  localparam int unsigned POSY_LSB  = POSX_LSB + POS_W;
  localparam int unsigned COL_LSB   = POSY_LSB + POS_W;
  localparam int unsigned ROW_LSB   = COL_LSB + CELL_W;
  localparam int unsigned HGT_LSB   = ROW_LSB + CELL_W;
  localparam int unsigned IN_DATA_W = HGT_LSB + HGT_W;

  localparam int unsigned OUT_DATA_W = HGT_W;

  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  localparam logic [INV_W-1:0] INV_RES_RST = INV_W'(65536);
  localparam logic [CNT_W-1:0] COUNT_RST   = CNT_W'(256);

  // result queue behind the pipeline
  localparam int unsigned OUT_DEPTH = 16;
  localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int unsigned OUT_CNT_W = OUT_PTR_W + 1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_X_HALF  = 3'd0,
    REG_Y_HALF  = 3'd1,
    REG_INV_RES = 3'd2,
    REG_COLS    = 3'd3,
    REG_ROWS    = 3'd4
  } reg_idx_e;

  // grid position on one axis
  typedef struct packed {
    logic             off;
    logic [IDX_W-1:0] idx;
  } axis_pos_t;

  // which bank holds which corner, handed to the blend stages
  typedef struct packed {
    logic valid;
    logic off;
    logic ix_odd;
    logic iy_odd;
    logic fx_nz;
    logic fy_nz;
  } corner_sel_t;

  typedef struct packed {
    logic             off_grid;
    logic [HGT_W-1:0] height;
  } result_t;

endpackage

// ===== hw/rtl/heightmap_triangle_interpolator.sv =====
// top level of the triangulated heightmap interpolator
//
//  channel  | dir | transfer when                     | content
//  s_axis   | in  | s_axis_tvalid & s_axis_tready     | height write or position query
//  m_axis   | out | m_axis_tvalid & m_axis_tready     | interpolated height, off-grid flag
//  apb      | in  | psel & penable & pwrite & pready  | extents, resolution, grid size
//
//  one item per cycle while the input is ready; a query result passes the input stages, the bank read
//  and the blend stages before it enters the output queue, through two 32x32 multiplies and the weight multiplies
//  the store sits in four parity banks so all corners come from one read; no clear pass
//  store entries are undefined after reset until written
//  input stalls only while 16 queries are held or in flight toward the output queue
`include "heightmap_triangle_interpolator_macros.svh"

module heightmap_triangle_interpolator import htri_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int unsigned MAX_ROWS    = DEF_MAX_ROWS,
  parameter int unsigned FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pos_x[31:0], pos_y[63:32], cell_column[71:64], cell_row[79:72], sample_height[111:80]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // opcode[0]
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // height_out[31:0]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // off_grid[0]
  output logic [0:0]            m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_AW-1:0]     paddr,
  input  logic [CFG_DW-1:0]     pwdata,
  output logic [CFG_DW-1:0]     prdata,
  output logic                  pready
);

  localparam int unsigned GRID_MAX   = 2 ** CELL_W;
  localparam int unsigned EFF_COLS   = (MAX_COLUMNS < GRID_MAX) ? MAX_COLUMNS : GRID_MAX;
  localparam int unsigned EFF_ROWS   = (MAX_ROWS < GRID_MAX) ? MAX_ROWS : GRID_MAX;
  localparam int unsigned HALF_COLS  = (EFF_COLS + 1) / 2;
  localparam int unsigned HALF_ROWS  = (EFF_ROWS + 1) / 2;
  localparam int unsigned BANK_DEPTH = HALF_COLS * HALF_ROWS;
  localparam int unsigned BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  // configuration
  logic [HALF_W-1:0] x_half_q, y_half_q;
  logic [INV_W-1:0]  inv_res_q;
  logic [CNT_W-1:0]  cols_q, rows_q;
  logic [CNT_W-1:0]  cols_eff, rows_eff;
  logic              cfg_we;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_e'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_half_q  <= '0;
      y_half_q  <= '0;
      inv_res_q <= INV_RES_RST;
      cols_q    <= COUNT_RST;
      rows_q    <= COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_X_HALF:  x_half_q  <= pwdata[HALF_W-1:0];
        REG_Y_HALF:  y_half_q  <= pwdata[HALF_W-1:0];
        REG_INV_RES: inv_res_q <= pwdata[INV_W-1:0];
        REG_COLS:    cols_q    <= pwdata[CNT_W-1:0];
        REG_ROWS:    rows_q    <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_X_HALF:  prdata = CFG_DW'(x_half_q);
      REG_Y_HALF:  prdata = CFG_DW'(y_half_q);
      REG_INV_RES: prdata = CFG_DW'(inv_res_q);
      REG_COLS:    prdata = CFG_DW'(cols_q);
      REG_ROWS:    prdata = CFG_DW'(rows_q);
      default:     prdata = '0;
    endcase
  end

  assign cols_eff = (32'(cols_q) > MAX_COLUMNS) ? CNT_W'(MAX_COLUMNS) : cols_q;
  assign rows_eff = (32'(rows_q) > MAX_ROWS) ? CNT_W'(MAX_ROWS) : rows_q;

  // input side and the three stages ahead of the store
  logic              in_fire, q_accept;
  logic              v1_q, v2_q, v3_q;
  opcode_e           op1_q, op2_q, op3_q;
  logic [CELL_W-1:0] col1_q, col2_q, col3_q;
  logic [CELL_W-1:0] row1_q, row2_q, row3_q;
  logic [HGT_W-1:0]  hgt1_q, hgt2_q, hgt3_q;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  assign q_accept = in_fire & (s_axis_tuser[0] == OP_QUERY);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= in_fire;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    op1_q  <= opcode_e'(s_axis_tuser[0]);
    col1_q <= s_axis_tdata[COL_LSB +: CELL_W];
    row1_q <= s_axis_tdata[ROW_LSB +: CELL_W];
    hgt1_q <= s_axis_tdata[HGT_LSB +: HGT_W];
    op2_q  <= op1_q;
    col2_q <= col1_q;
    row2_q <= row1_q;
    hgt2_q <= hgt1_q;
    op3_q  <= op2_q;
    col3_q <= col2_q;
    row3_q <= row2_q;
    hgt3_q <= hgt2_q;
  end

  axis_pos_t            x_pos, y_pos;
  logic [FRAC_BITS-1:0] fx, fy;

  htri_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk_i     (clk_i),
    .pos_i     (s_axis_tdata[POSX_LSB +: POS_W]),
    .half_i    (x_half_q),
    .inv_res_i (inv_res_q),
    .count_i   (cols_eff),
    .pos_o     (x_pos),
    .frac_o    (fx)
  );

  htri_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk_i     (clk_i),
    .pos_i     (s_axis_tdata[POSY_LSB +: POS_W]),
    .half_i    (y_half_q),
    .inv_res_i (inv_res_q),
    .count_i   (rows_eff),
    .pos_o     (y_pos),
    .frac_o    (fy)
  );

  // store access stage: writes and reads happen here in item order, so a query
  // always sees every earlier write and never a later one
  logic                   wr_en, rd_en;
  logic [1:0]             wsel;
  logic [BANK_AW-1:0]     waddr;
  logic [CELL_W-1:0]      ix, iy;
  logic [3:0][HGT_W-1:0]  rd_data;

  assign wr_en = v3_q & (op3_q == OP_WRITE)
               & (32'(col3_q) < MAX_COLUMNS) & (32'(row3_q) < MAX_ROWS);
  assign rd_en = v3_q & (op3_q == OP_QUERY);
  assign wsel  = {row3_q[0], col3_q[0]};
  assign waddr = BANK_AW'(32'(row3_q[CELL_W-1:1]) * HALF_COLS + 32'(col3_q[CELL_W-1:1]));
  assign ix    = x_pos.idx[CELL_W-1:0];
  assign iy    = y_pos.idx[CELL_W-1:0];

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam bit PC = ((b % 2) == 1);
    localparam bit PR = ((b / 2) == 1);
    logic [CELL_W-1:0]  ch, rh;
    logic [BANK_AW-1:0] raddr;

    // nearest column and row of this bank's parity at or above the floor index
    assign ch    = PC ? {1'b0, ix[CELL_W-1:1]} : {1'b0, ix[CELL_W-1:1]} + CELL_W'(ix[0]);
    assign rh    = PR ? {1'b0, iy[CELL_W-1:1]} : {1'b0, iy[CELL_W-1:1]} + CELL_W'(iy[0]);
    assign raddr = BANK_AW'(32'(rh) * HALF_COLS + 32'(ch));

    htri_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank (
      .clk_i   (clk_i),
      .we_i    (wr_en & (wsel == 2'(b))),
      .waddr_i (waddr),
      .wdata_i (hgt3_q),
      .re_i    (rd_en),
      .raddr_i (raddr),
      .rdata_o (rd_data[b])
    );
  end

  corner_sel_t          ctl4_q;
  logic [FRAC_BITS-1:0] fx4_q, fy4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl4_q <= '0;
    end else begin
      ctl4_q.valid  <= rd_en;
      ctl4_q.off    <= x_pos.off | y_pos.off;
      ctl4_q.ix_odd <= ix[0];
      ctl4_q.iy_odd <= iy[0];
      ctl4_q.fx_nz  <= (fx != '0);
      ctl4_q.fy_nz  <= (fy != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    fx4_q <= fx;
    fy4_q <= fy;
  end

  logic    blend_valid;
  result_t blend_res;

  htri_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sel_i   (ctl4_q),
    .fx_i    (fx4_q),
    .fy_i    (fy4_q),
    .rd_i    (rd_data),
    .valid_o (blend_valid),
    .res_o   (blend_res)
  );

  // result queue; a slot is reserved for every query at acceptance
  result_t              fifo_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OUT_CNT_W-1:0] cnt_q, cnt_d, resv_q, resv_d;
  logic                 out_pop;
  result_t              head;

  assign out_pop       = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = (resv_q != OUT_CNT_W'(OUT_DEPTH));
  assign head          = fifo_q[rd_ptr_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = head.height;
  assign m_axis_tuser  = head.off_grid;

  always_comb begin
    case ({blend_valid, out_pop})
      2'b10:   cnt_d = cnt_q + OUT_CNT_W'(1);
      2'b01:   cnt_d = cnt_q - OUT_CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
    case ({q_accept, out_pop})
      2'b10:   resv_d = resv_q + OUT_CNT_W'(1);
      2'b01:   resv_d = resv_q - OUT_CNT_W'(1);
      default: resv_d = resv_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      resv_q   <= '0;
    end else begin
      if (blend_valid) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (out_pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
      cnt_q  <= cnt_d;
      resv_q <= resv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blend_valid) begin
      fifo_q[wr_ptr_q] <= blend_res;
    end
  end

  `HTRI_ASSERT_NEVER(a_queue_overflow, blend_valid && (cnt_q == OUT_CNT_W'(OUT_DEPTH)) && !out_pop, "result queue overflow")
  `HTRI_ASSERT(a_credit_covers_queue, resv_q >= cnt_q, "queue holds more results than were reserved")
  `HTRI_ASSERT(a_off_grid_zero, (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0), "off-grid result with nonzero height")

endmodule

// ===== hw/rtl/htri_bank.sv =====
// one parity bank of the height store, registered read
module htri_bank import htri_pkg::*; #(
  parameter int unsigned DEPTH = 2,
  parameter int unsigned AW    = 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [HGT_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [HGT_W-1:0] rdata_o
);

  logic [HGT_W-1:0] mem_q [DEPTH];
  logic [HGT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/htri_axis.sv =====
// position to grid index and fraction for one axis, three register stages
module htri_axis import htri_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk_i,
  input  logic [POS_W-1:0]     pos_i,
  input  logic [HALF_W-1:0]    half_i,
  input  logic [INV_W-1:0]     inv_res_i,
  input  logic [CNT_W-1:0]     count_i,
  output axis_pos_t            pos_o,
  output logic [FRAC_BITS-1:0] frac_o
);

  localparam int unsigned PROD_W = (SUM_W - 1) + INV_W;
  localparam int unsigned INT_W  = PROD_W - 2 * FRAC_BITS;

  logic signed [SUM_W-1:0]  s_q;
  logic                     neg_q;
  logic [PROD_W-1:0]        prod_q;
  logic [INT_W-1:0]         int_part;
  logic [FRAC_BITS-1:0]     frac;
  logic [IDX_W:0]           idx_inc;
  logic                     off;
  axis_pos_t                pos_q;
  logic [FRAC_BITS-1:0]     frac_q;

  // the shifted position never exceeds 32 bits unsigned once it is not negative
  always_ff @(posedge clk_i) begin
    s_q    <= $signed({pos_i[POS_W-1], pos_i}) + $signed({2'b00, half_i});
    neg_q  <= s_q[SUM_W-1];
    prod_q <= PROD_W'(s_q[SUM_W-2:0]) * PROD_W'(inv_res_i);
  end

  always_comb begin
    int_part = prod_q[PROD_W-1 -: INT_W];
    frac     = prod_q[2*FRAC_BITS-1 -: FRAC_BITS];
    idx_inc  = {1'b0, int_part[IDX_W-1:0]} + (IDX_W+1)'(1);
    off      = neg_q
             | (count_i == '0)
             | (int_part[INT_W-1:IDX_W] != '0)
             | (int_part[IDX_W-1:0] >= count_i)
             | ((idx_inc == {1'b0, count_i}) && (frac != '0));
  end

  always_ff @(posedge clk_i) begin
    pos_q.off <= off;
    pos_q.idx <= int_part[IDX_W-1:0];
    frac_q    <= frac;
  end

  assign pos_o  = pos_q;
  assign frac_o = frac_q;

endmodule

// ===== hw/rtl/htri_blend.sv =====
// corner pick, triangle weights, rounding and saturation
module htri_blend import htri_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  corner_sel_t                 sel_i,
  input  logic [FRAC_BITS-1:0]        fx_i,
  input  logic [FRAC_BITS-1:0]        fy_i,
  input  logic [3:0][HGT_W-1:0]       rd_i,
  output logic                        valid_o,
  output result_t                     res_o
);

  localparam int unsigned DIFF_W = HGT_W + 1;
  localparam int unsigned PRD_W  = FRAC_BITS + 1 + DIFF_W;
  localparam int unsigned ACC_W  = PRD_W + 1;
  localparam int unsigned SHF_W  = ACC_W - FRAC_BITS;
  localparam int unsigned HS_W   = SHF_W + 1;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(2 ** (FRAC_BITS - 1));

  logic [1:0]               b00, b10, b01, b11;
  logic signed [HGT_W-1:0]  h00, h10, h01, h11;
  logic                     left;
  logic signed [DIFF_W-1:0] d1, d2;

  logic                     vd_q, offd_q;
  logic [FRAC_BITS-1:0]     fxd_q, fyd_q;
  logic signed [HGT_W-1:0]  h00d_q;
  logic signed [DIFF_W-1:0] d1_q, d2_q;

  logic                     vp_q, offp_q;
  logic signed [HGT_W-1:0]  h00p_q;
  logic signed [PRD_W-1:0]  p1_q, p2_q;

  logic                     va_q, offa_q;
  logic signed [HGT_W-1:0]  h00a_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic signed [HS_W-1:0]   hs;
  logic                     fits;

  // a zero fraction folds the ceil corner onto the floor one
  always_comb begin
    b00  = {sel_i.iy_odd, sel_i.ix_odd};
    b10  = {sel_i.iy_odd, ~sel_i.ix_odd};
    b01  = {~sel_i.iy_odd, sel_i.ix_odd};
    b11  = {~sel_i.iy_odd, ~sel_i.ix_odd};
    h00  = $signed(rd_i[b00]);
    h10  = sel_i.fx_nz ? $signed(rd_i[b10]) : h00;
    h01  = sel_i.fy_nz ? $signed(rd_i[b01]) : h00;
    h11  = sel_i.fx_nz ? (sel_i.fy_nz ? $signed(rd_i[b11]) : $signed(rd_i[b10])) : h01;
    left = (fx_i <= fy_i);
    if (left) begin
      d1 = DIFF_W'(h11) - DIFF_W'(h01);
      d2 = DIFF_W'(h01) - DIFF_W'(h00);
    end else begin
      d1 = DIFF_W'(h10) - DIFF_W'(h00);
      d2 = DIFF_W'(h11) - DIFF_W'(h10);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      vp_q <= 1'b0;
      va_q <= 1'b0;
    end else begin
      vd_q <= sel_i.valid;
      vp_q <= vd_q;
      va_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    offd_q <= sel_i.off;
    fxd_q  <= fx_i;
    fyd_q  <= fy_i;
    h00d_q <= h00;
    d1_q   <= d1;
    d2_q   <= d2;

    offp_q <= offd_q;
    h00p_q <= h00d_q;
    p1_q   <= PRD_W'($signed({1'b0, fxd_q})) * PRD_W'(d1_q);
    p2_q   <= PRD_W'($signed({1'b0, fyd_q})) * PRD_W'(d2_q);

    offa_q <= offp_q;
    h00a_q <= h00p_q;
    acc_q  <= ACC_W'(p1_q) + ACC_W'(p2_q) + RND;
  end

  // round half up is the floor of the biased sum
  always_comb begin
    hs   = HS_W'(h00a_q) + HS_W'($signed(acc_q[ACC_W-1:FRAC_BITS]));
    fits = (hs[HS_W-1:HGT_W-1] == '0) || (hs[HS_W-1:HGT_W-1] == '1);
    res_o.off_grid = offa_q;
    if (offa_q) begin
      res_o.height = '0;
    end else if (fits) begin
      res_o.height = hs[HGT_W-1:0];
    end else if (hs[HS_W-1]) begin
      res_o.height = {1'b1, {(HGT_W-1){1'b0}}};
    end else begin
      res_o.height = {1'b0, {(HGT_W-1){1'b1}}};
    end
  end

  assign valid_o = va_q;

endmodule

// ===== verif/tb.sv =====
// self-checking testbench for the heightmap interpolator: directed table, then random phases
`timescale 1ns / 100ps

module tb;
  import htri_pkg::*;

  localparam int unsigned FRAC     = DEF_FRAC_BITS;
  localparam int unsigned COLS_MAX = DEF_MAX_COLUMNS;
  localparam int unsigned ROWS_MAX = DEF_MAX_ROWS;

  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    opcode_e     op;
    logic [31:0] px;
    logic [31:0] py;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [31:0] hgt;
    logic        typed;
    logic [31:0] want_h;
    logic        want_off;
  } stim_row_t;

  localparam int NDIR = 22;

  // unit corner cell: 1.0, 2.0, 3.0, 4.0 m; then grid edges and height extremes
  localparam stim_row_t DIRECTED [NDIR] = '{
    '{OP_WRITE, 32'h0,         32'h0,         8'd0,   8'd0,   32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE, 32'h0,         32'h0,         8'd1,   8'd0,   32'h0002_0000, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE, 32'h0,         32'h0,         8'd0,   8'd1,   32'h0003_0000, 1'b0, 32'h0, 1'b0},
    '{OP_WRITE, 32'h0,         32'h0,         8'd1,   8'd1,   32'h0004_0000, 1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h0,         32'h0,         8'd0,   8'd0,   32'h0,
      1'b1, 32'h0001_0000, 1'b0},
    '{OP_QUERY, 32'h0001_0000, 32'h0001_0000, 8'd0,   8'd0,   32'h0,
      1'b1, 32'h0004_0000, 1'b0},
    // right triangle, tie on the diagonal, left triangle, both grid lines
    '{OP_QUERY, 32'h0000_8000, 32'h0000_4000, 8'd0,   8'd0,   32'h0,         1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h0000_8000, 32'h0000_8000, 8'd0,   8'd0,   32'h0,         1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h0000_4000, 32'h0000_C000, 8'd0,   8'd0,   32'h0,         1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h0,         32'h0000_8000, 8'd0,   8'd0,   32'h0,         1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h0000_8000, 32'h0,         8'd0,   8'd0,   32'h0,         1'b0, 32'h0, 1'b0},
    // negative shifted position and coordinate far beyond the grid
    '{OP_QUERY, 32'hFFFF_FFFF, 32'h0,         8'd0,   8'd0,   32'h0,         1'b1, 32'h0, 1'b1},
    '{OP_QUERY, 32'h0,         32'h8000_0000, 8'd0,   8'd0,   32'h0,         1'b1, 32'h0, 1'b1},
    '{OP_QUERY, 32'h7FFF_FFFF, 32'h0,         8'd0,   8'd0,   32'h0,         1'b1, 32'h0, 1'b1},
    '{OP_WRITE, 32'h0,         32'h0,         8'd0,   8'd255, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h0,         32'h00FF_0000, 8'd0,   8'd0,   32'h0,
      1'b1, 32'h7FFF_FFFF, 1'b0},
    '{OP_WRITE, 32'h0,         32'h0,         8'd255, 8'd255, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h00FF_0000, 32'h00FF_0000, 8'd0,   8'd0,   32'h0,
      1'b1, 32'h8000_0000, 1'b0},
    '{OP_WRITE, 32'h0,         32'h0,         8'd1,   8'd255, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{OP_QUERY, 32'h0000_8000, 32'h00FF_0000, 8'd0,   8'd0,   32'h0,         1'b0, 32'h0, 1'b0},
    // last grid line plus one lsb
    '{OP_QUERY, 32'h00FF_0001, 32'h0,         8'd0,   8'd0,   32'h0,         1'b1, 32'h0, 1'b1},
    '{OP_QUERY, 32'h0,         32'h00FF_0001, 8'd0,   8'd0,   32'h0,         1'b1, 32'h0, 1'b1}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // pos_x[31:0], pos_y[63:32], cell_column[71:64], cell_row[79:72], sample_height[111:80]
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  // opcode[0]
  logic [0:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // height_out[31:0]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // off_grid[0]
  logic [0:0]            m_axis_tuser;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [CFG_AW-1:0]     paddr         = '0;
  logic [CFG_DW-1:0]     pwdata        = '0;
  logic [CFG_DW-1:0]     prdata;
  logic                  pready;

  heightmap_triangle_interpolator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #2 clk_i = ~clk_i;

  // local copy of the register file and the height store
  logic [HALF_W-1:0]       cfg_xh   = '0;
  logic [HALF_W-1:0]       cfg_yh   = '0;
  logic [INV_W-1:0]        cfg_inv  = INV_RES_RST;
  logic [CNT_W-1:0]        cfg_cols = COUNT_RST;
  logic [CNT_W-1:0]        cfg_rows = COUNT_RST;
  logic signed [HGT_W-1:0] height_model [0:COLS_MAX*ROWS_MAX-1];
  bit                      cell_written [0:COLS_MAX*ROWS_MAX-1];

  result_t expected_heights [$];

  int send_idle_pct = 17;
  int recv_idle_pct = 85;
  int n_items       = 0;
  int n_queries     = 0;
  int n_offgrid     = 0;
  int n_checked     = 0;
  int n_settings    = 0;
  int n_errors      = 0;
  int quiet_cycles  = 0;

  function automatic int unsigned eff_count(input logic [CNT_W-1:0] cnt, input int unsigned lim);
    return (cnt > lim) ? lim : int'(cnt);
  endfunction

  // shift, scale and split one axis; returns 1 when the point is on the grid
  function automatic bit axis_map(input logic [31:0] pos, input logic [HALF_W-1:0] half,
                                  input int unsigned count, output int unsigned idx,
                                  output int unsigned frac);
    longint      s;
    logic [63:0] prod;
    logic [63:0] q;
    logic [63:0] i;
    idx  = 0;
    frac = 0;
    s = longint'($signed(pos)) + longint'({1'b0, half});
    if (s < 0) return 1'b0;
    if ((s >>> 32) != 0 && cfg_inv != 0) return 1'b0;
    prod = {32'b0, s[31:0]} * {32'b0, cfg_inv};
    q    = prod >> FRAC;
    i    = q >> FRAC;
    if (count == 0 || i >= 64'(count)) return 1'b0;
    if (i == 64'(count - 1) && q[FRAC-1:0] != 0) return 1'b0;
    idx  = int'(i);
    frac = int'(q[FRAC-1:0]);
    return 1'b1;
  endfunction

  function automatic result_t predict_height(input logic [31:0] px, input logic [31:0] py);
    result_t     r;
    int unsigned ix, iy, fx, fy, cx, cy;
    longint      h00, h01, h10, h11, wx, wy, acc, h;
    r.off_grid = 1'b1;
    r.height   = '0;
    if (!axis_map(px, cfg_xh, eff_count(cfg_cols, COLS_MAX), ix, fx) ||
        !axis_map(py, cfg_yh, eff_count(cfg_rows, ROWS_MAX), iy, fy))
      return r;
    // a zero fraction collapses the ceil corner onto the floor one
    cx  = (fx != 0) ? ix + 1 : ix;
    cy  = (fy != 0) ? iy + 1 : iy;
    h00 = longint'(height_model[iy * COLS_MAX + ix]);
    h01 = longint'(height_model[cy * COLS_MAX + ix]);
    h10 = longint'(height_model[iy * COLS_MAX + cx]);
    h11 = longint'(height_model[cy * COLS_MAX + cx]);
    wx  = fx;
    wy  = fy;
    if (fx <= fy)
      acc = wx * (h11 - h01) + wy * (h01 - h00);
    else
      acc = wx * (h10 - h00) + wy * (h11 - h10);
    h = h00 + ((acc + (longint'(1) << (FRAC - 1))) >>> FRAC);
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    r.off_grid = 1'b0;
    r.height   = h[31:0];
    return r;
  endfunction

  function automatic logic [15:0] pick_frac();
    return ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom_range(1, 65535));
  endfunction

  // position that lands near a chosen grid coordinate under the current settings
  function automatic logic [31:0] aim_axis(input logic [HALF_W-1:0] half,
                                           input int unsigned count, input logic [15:0] frac);
    int unsigned     r;
    longint unsigned g, s;
    r = $urandom_range(0, 99);
    if (r < 10 || count == 0) return $urandom;
    if (r < 20)
      g = (longint'(count - 1) << FRAC) + $urandom_range(0, 2);
    else
      g = (longint'($urandom_range(0, count - 1)) << FRAC) + frac;
    if (cfg_inv == 0)
      s = $urandom;
    else
      s = ((g << FRAC) + cfg_inv - 1) / cfg_inv;
    return 32'(s - longint'({1'b0, half}));
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_errors++;
  endtask

  task automatic send_item(input opcode_e op, input logic [31:0] px, input logic [31:0] py,
                           input logic [7:0] col, input logic [7:0] row,
                           input logic [31:0] hgt, input bit typed,
                           input logic [31:0] want_h, input bit want_off);
    int      gap;
    result_t want;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {hgt, row, col, py, px};
    do @(posedge clk_i); while (!s_axis_tready);
    n_items++;
    if (op == OP_WRITE) begin
      height_model[{row, col}] = hgt;
      cell_written[{row, col}] = 1'b1;
    end else begin
      if (typed) begin
        want.height   = want_h;
        want.off_grid = want_off;
      end else begin
        want = predict_height(px, py);
      end
      n_queries++;
      if (want.off_grid) n_offgrid++;
      expected_heights.push_back(want);
    end
  endtask

  // any corner the query will read gets a sample first
  task automatic send_query(input logic [31:0] px, input logic [31:0] py, input bit typed,
                            input logic [31:0] want_h, input bit want_off);
    int unsigned ix, iy, fx, fy, a, b;
    int unsigned xs [2];
    int unsigned ys [2];
    if (axis_map(px, cfg_xh, eff_count(cfg_cols, COLS_MAX), ix, fx) &&
        axis_map(py, cfg_yh, eff_count(cfg_rows, ROWS_MAX), iy, fy)) begin
      xs[0] = ix;
      xs[1] = (fx != 0) ? ix + 1 : ix;
      ys[0] = iy;
      ys[1] = (fy != 0) ? iy + 1 : iy;
      for (a = 0; a < 2; a++)
        for (b = 0; b < 2; b++)
          if (!cell_written[ys[b] * COLS_MAX + xs[a]])
            send_item(OP_WRITE, $urandom, $urandom, 8'(xs[a]), 8'(ys[b]), $urandom,
                      1'b0, '0, 1'b0);
    end
    send_item(OP_QUERY, px, py, 8'($urandom), 8'($urandom), $urandom, typed, want_h, want_off);
  endtask

  task automatic random_item();
    int unsigned ce, re;
    logic [7:0]  col, row;
    logic [15:0] fx, fy;
    ce = eff_count(cfg_cols, COLS_MAX);
    re = eff_count(cfg_rows, ROWS_MAX);
    if ($urandom_range(0, 99) < 30) begin
      // mostly refresh samples inside the active grid
      if ($urandom_range(0, 9) < 7 && ce > 0 && re > 0) begin
        col = 8'($urandom_range(0, ce - 1));
        row = 8'($urandom_range(0, re - 1));
      end else begin
        col = 8'($urandom);
        row = 8'($urandom);
      end
      send_item(OP_WRITE, $urandom, $urandom, col, row, $urandom, 1'b0, '0, 1'b0);
    end else begin
      fx = pick_frac();
      fy = ($urandom_range(0, 9) == 0) ? fx : pick_frac();
      send_query(aim_axis(cfg_xh, ce, fx), aim_axis(cfg_yh, re, fy), 1'b0, '0, 1'b0);
    end
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_AW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_X_HALF:  cfg_xh   = val[HALF_W-1:0];
      REG_Y_HALF:  cfg_yh   = val[HALF_W-1:0];
      REG_INV_RES: cfg_inv  = val[INV_W-1:0];
      REG_COLS:    cfg_cols = val[CNT_W-1:0];
      REG_ROWS:    cfg_rows = val[CNT_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // writes carry no result, so allow the pipeline to empty after the last query
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_heights.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // n counts every stream item sent, corner samples included
  task automatic run_phase(input logic [31:0] xh, input logic [31:0] yh,
                           input logic [31:0] inv, input logic [31:0] cols,
                           input logic [31:0] rows, input int n,
                           input int sidle, input int ridle);
    int base_items;
    wait_drained();
    // unused upper bits of each register carry random values
    apb_write(REG_X_HALF,  xh | ($urandom & 32'h8000_0000));
    apb_write(REG_Y_HALF,  yh | ($urandom & 32'h8000_0000));
    apb_write(REG_INV_RES, inv);
    apb_write(REG_COLS,    cols | ($urandom & 32'hFFFF_FE00));
    apb_write(REG_ROWS,    rows | ($urandom & 32'hFFFF_FE00));
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    n_settings++;
    base_items = n_items;
    while (n_items - base_items < n) random_item();
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_heights.size() == 0) begin
        flag_error($sformatf("result transaction with nothing expected: height %h off %b",
                             m_axis_tdata, m_axis_tuser[0]));
      end else begin
        want = expected_heights.pop_front();
        n_checked++;
        if (m_axis_tdata !== want.height)
          flag_error($sformatf("height_out %h, expected %h", m_axis_tdata, want.height));
        if (m_axis_tuser[0] !== want.off_grid)
          flag_error($sformatf("off_grid %b, expected %b", m_axis_tuser[0], want.off_grid));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("heightmap_triangle_interpolator verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int k;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table under the reset settings
    for (k = 0; k < NDIR; k++) begin
      if (DIRECTED[k].op == OP_WRITE)
        send_item(OP_WRITE, DIRECTED[k].px, DIRECTED[k].py, DIRECTED[k].col,
                  DIRECTED[k].row, DIRECTED[k].hgt, 1'b0, '0, 1'b0);
      else
        send_query(DIRECTED[k].px, DIRECTED[k].py, DIRECTED[k].typed,
                   DIRECTED[k].want_h, DIRECTED[k].want_off);
    end

    run_phase(32'h0008_0000, 32'h0004_0000, 32'h0001_0000, 32'd16,  32'd9,   200, 17, 85);
    run_phase(32'h7FFF_FFFF, 32'h0,         32'h0002_0000, 32'd256, 32'd256, 150, 17, 85);
    // smallest nonzero reciprocal resolution on a two by two grid
    run_phase(32'h0,         32'h7FFF_FFFF, 32'h0000_0001, 32'd2,   32'd2,   100, 17, 85);
    run_phase(32'h0123_4567, 32'd100,       32'hFFFF_FFFF, 32'd3,   32'd200, 150, 85, 17);
    // zero resolution maps every non-negative shifted position onto the first grid point
    run_phase(32'h0001_8000, 32'h0000_4000, 32'h0,         32'd5,   32'd7,   60,  85, 17);
    // zero column count puts every point off the grid
    run_phase(32'h0010_0000, 32'h0010_0000, 32'h0001_0000, 32'd0,   32'd300, 40,  85, 17);
    // counts above the maximum are clamped, a single row allows only its grid line
    run_phase(32'h0,         32'h0,         32'h0000_8000, 32'd511, 32'd1,   80,  0,  0);
    run_phase(32'h0040_0000, 32'h0020_0000, 32'h0000_4000, 32'd300, 32'd256, 200, 0,  0);
    run_phase($urandom_range(0, 32'h0100_0000), $urandom_range(0, 32'h0100_0000),
              $urandom_range(32'h4000, 32'h4_0000), $urandom_range(2, 64),
              $urandom_range(2, 64), 110, 0, 0);
    run_phase($urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
              $urandom, $urandom_range(2, 256), $urandom_range(2, 256), 110, 0, 0);

    wait_drained();
    $display("sent %0d items (%0d queries, %0d off the grid) under %0d register settings",
             n_items, n_queries, n_offgrid, n_settings + 1);
    $display("checked %0d results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0)
      $display("heightmap_triangle_interpolator verification clean");
    else
      $display("heightmap_triangle_interpolator verification failed");
    $finish;
  end

endmodule
